// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by spa_back
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SPA_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("%m: check failed");
`define SPA_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error("%m: forbidden condition");
`else
`define SPA_ASSERT(lbl, ck, rn, prop)
`define SPA_NEVER(lbl, ck, rn, cond)
`endif
`endif

// ----- hw/rtl/spa_pkg.sv -----
// shared types, codes and helper functions of the subpage pool allocator
// no dependencies
package spa_pkg;
	localparam int ADDR_BITS  = 48;
	localparam int POOLS_DEF  = 8;
	localparam int SLOTS_DEF  = 512;
	localparam int SLOT_SHIFT = 12;
	localparam int BASE_SHIFT = 21;
	localparam int BASE_W     = ADDR_BITS - BASE_SHIFT;
	localparam int CNT_W      = 16;
	localparam int QDEPTH     = 2;
	localparam int QPB        = 1;
	localparam logic [63:0] NEW_POOL_WORD0 = 64'h3;

	localparam logic [2:0] OP_ALLOC = 3'd0;
	localparam logic [2:0] OP_FREE  = 3'd1;
	localparam logic [2:0] OP_GET   = 3'd2;
	localparam logic [2:0] OP_PUT   = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NO_POOL = 2'd1;
	localparam logic [1:0] ST_NO_SLOT = 2'd2;

	typedef enum logic [2:0] {
		K_ALLOC, K_FREE, K_GET, K_PUT, K_READ, K_NULL, K_NOP
	} kind_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_A_POOL, S_A_RD, S_A_CHK, S_A_NEW, S_A_OPEN,
		S_SRCH, S_F_RD, S_F_CHK, S_C_RD, S_C_CHK, S_DONE
	} back_state_t;

	typedef struct packed {
		logic [2:0]           opcode;
		logic [ADDR_BITS-1:0] phys_addr;
		logic [ADDR_BITS-1:0] spare_base;
		logic                 spare_valid;
	} req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [ADDR_BITS-1:0] slot_addr;
		logic                 spare_used;
		logic                 zeroed;
		logic [CNT_W-1:0]     ref_count;
	} rsp_t;

	typedef struct packed {
		kind_t                kind;
		logic [ADDR_BITS-1:0] addr;
		logic [BASE_W-1:0]    spare_pfn;
		logic                 spare_valid;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} back_ctl_t;

	// bits of bitmap word w that map to real slots
	function automatic logic [63:0] word_valid(input int w, input int slots);
		int rem;
		rem = slots - w * 64;
		if (rem >= 64)
			return '1;
		return (64'd1 << rem) - 64'd1;
	endfunction

	function automatic logic [5:0] lowest_set(input logic [63:0] v);
		logic [5:0] n;
		n = 6'd63;
		for (int i = 63; i >= 0; i--)
			if (v[i])
				n = 6'(i);
		return n;
	endfunction
endpackage

// ----- hw/rtl/spa_queue.sv -----
// two-entry command queue between the front decoder and the back sequencer
// depends on spa_pkg
module spa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  spa_pkg::cmd_t   push_cmd,
	input  logic            pop,
	output spa_pkg::cmd_t   head,
	output spa_pkg::q_stat_t stat
);
	import spa_pkg::*;

	cmd_t           mem_q [QDEPTH];
	logic [QPB-1:0] wr_q;
	logic [QPB-1:0] rd_q;
	logic [QPB:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPB'(1);
			if (pop)
				rd_q <= rd_q + QPB'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QPB+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QPB+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_cmd;
	end

	assign head       = mem_q[rd_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == (QPB+1)'(QDEPTH));
endmodule

// ----- hw/rtl/spa_front.sv -----
// front end: takes requests and classifies them into queue commands
// depends on spa_pkg
module spa_front (
	input  logic              start,
	output logic              busy,
	input  spa_pkg::req_t     req,
	input  spa_pkg::q_stat_t  qs,
	input  spa_pkg::back_ctl_t ctl,
	output logic              push,
	output spa_pkg::cmd_t     cmd
);
	import spa_pkg::*;

	assign busy = qs.full || ctl.clearing;
	assign push = start && !busy;

	always_comb begin
		cmd.addr        = req.phys_addr;
		cmd.spare_pfn   = req.spare_base[ADDR_BITS-1:BASE_SHIFT];
		cmd.spare_valid = req.spare_valid;
		unique case (req.opcode)
			OP_ALLOC: cmd.kind = K_ALLOC;
			// free of a null address is rejected up front
			OP_FREE:  cmd.kind = (req.phys_addr == '0) ? K_NULL : K_FREE;
			OP_GET:   cmd.kind = K_GET;
			OP_PUT:   cmd.kind = K_PUT;
			OP_READ:  cmd.kind = K_READ;
			default:  cmd.kind = K_NOP;
		endcase
	end
endmodule

// ----- hw/rtl/spa_back.sv -----
// back end: sequencer that owns pool table, slot bitmaps and cow counts
// depends on spa_pkg and assert_macros.svh
`include "assert_macros.svh"
module spa_back #(
	parameter int POOLS = spa_pkg::POOLS_DEF,
	parameter int SLOTS = spa_pkg::SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  spa_pkg::cmd_t      head,
	input  spa_pkg::q_stat_t   qs,
	output spa_pkg::back_ctl_t ctl,
	output logic               rsp_valid,
	output spa_pkg::rsp_t      rsp
);
	import spa_pkg::*;

	localparam int PB        = (POOLS > 1) ? $clog2(POOLS) : 1;
	localparam int CB        = $clog2(POOLS + 1);
	localparam int SB        = $clog2(SLOTS);
	localparam int USED_W    = $clog2(SLOTS + 1);
	localparam int WORDS     = (SLOTS + 63) / 64;
	localparam int WB        = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int MAP_DEPTH = POOLS * WORDS;
	localparam int MAB       = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int COW_DEPTH = POOLS * SLOTS;
	localparam int CAB       = $clog2(COW_DEPTH);
	localparam logic [WB-1:0] LAST_W = WB'(WORDS - 1);

	back_state_t         state_q, state_d;
	cmd_t                cmd_q;
	rsp_t                res_q;
	logic [PB-1:0]       p_q;
	logic [WB-1:0]       w_q;
	logic [SB-1:0]       slot_q;
	logic [CB-1:0]       cnt_q;
	logic [CAB-1:0]      clr_q;
	logic [BASE_W-1:0]   base_q [POOLS];
	logic [USED_W-1:0]   used_q [POOLS];

	logic [63:0]         map_mem [MAP_DEPTH];
	logic [63:0]         map_rd_q;
	logic [CNT_W-1:0]    cow_mem [COW_DEPTH];
	logic [CNT_W-1:0]    cow_rd_q;

	logic                map_we, cow_we;
	logic [MAB-1:0]      map_waddr, map_raddr;
	logic [63:0]         map_wdata;
	logic [CAB-1:0]      cow_waddr, cow_raddr;
	logic [CNT_W-1:0]    cow_wdata;

	logic [PB-1:0]        new_idx;
	logic [ADDR_BITS-1:0] base_full, off;
	logic                 hit, has_room, can_open;
	logic [SB-1:0]        hit_slot, new_slot;
	logic [WB-1:0]        slot_word;
	logic [63:0]          freebits;
	logic [5:0]           free_bit;

	function automatic logic [MAB-1:0] map_idx(input logic [PB-1:0] p, input logic [WB-1:0] w);
		return MAB'(int'(p) * WORDS + int'(w));
	endfunction

	function automatic logic [CAB-1:0] cow_idx(input logic [PB-1:0] p, input logic [SB-1:0] s);
		return CAB'(int'(p) * SLOTS + int'(s));
	endfunction

	assign new_idx   = PB'(cnt_q);
	assign base_full = {base_q[p_q], {BASE_SHIFT{1'b0}}};
	assign off       = cmd_q.addr - base_full;
	assign hit       = (cmd_q.addr >= base_full) &&
	                   ((off >> SLOT_SHIFT) < ADDR_BITS'(SLOTS));
	assign hit_slot  = SB'(off >> SLOT_SHIFT);
	assign slot_word = WB'(slot_q >> 6);
	assign has_room  = used_q[p_q] < USED_W'(SLOTS);
	assign can_open  = cmd_q.spare_valid && (cnt_q < CB'(POOLS));
	assign freebits  = ~map_rd_q & word_valid(int'(w_q), SLOTS);
	assign free_bit  = lowest_set(freebits);
	assign new_slot  = SB'(int'(w_q) * 64 + int'(free_bit));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:  if (clr_q == CAB'(COW_DEPTH - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (!qs.empty) begin
					unique case (head.kind)
						K_ALLOC:               state_d = S_A_POOL;
						K_FREE, K_GET, K_PUT,
						K_READ:                state_d = S_SRCH;
						default:               state_d = S_DONE;
					endcase
				end
			end
			S_A_POOL: begin
				if (cnt_q == '0)
					state_d = S_A_NEW;
				else if (has_room)
					state_d = S_A_RD;
				else if (p_q == '0)
					state_d = S_A_NEW;
			end
			S_A_RD:   state_d = S_A_CHK;
			S_A_CHK: begin
				if (freebits != '0 || w_q == LAST_W)
					state_d = S_DONE;
				else
					state_d = S_A_RD;
			end
			S_A_NEW:  state_d = can_open ? S_A_OPEN : S_DONE;
			S_A_OPEN: if (w_q == LAST_W) state_d = S_DONE;
			S_SRCH: begin
				if (cnt_q == '0)
					state_d = S_DONE;
				else if (hit)
					state_d = (cmd_q.kind == K_FREE) ? S_F_RD : S_C_RD;
				else if (p_q == '0)
					state_d = S_DONE;
			end
			S_F_RD:   state_d = S_F_CHK;
			S_F_CHK:  state_d = S_DONE;
			S_C_RD:   state_d = S_C_CHK;
			S_C_CHK:  state_d = S_DONE;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory ports and handshake outputs
	always_comb begin
		map_we       = 1'b0;
		map_waddr    = map_idx(p_q, w_q);
		map_raddr    = map_idx(p_q, w_q);
		map_wdata    = map_rd_q;
		cow_we       = 1'b0;
		cow_waddr    = cow_idx(p_q, slot_q);
		cow_raddr    = cow_idx(p_q, slot_q);
		cow_wdata    = '0;
		ctl.pop      = 1'b0;
		ctl.clearing = 1'b0;
		rsp_valid    = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ctl.clearing = 1'b1;
				cow_we       = 1'b1;
				cow_waddr    = clr_q;
			end
			S_IDLE:  ctl.pop = !qs.empty;
			S_A_CHK: begin
				if (freebits != '0) begin
					map_we    = 1'b1;
					map_wdata = map_rd_q | (64'd1 << free_bit);
					cow_we    = 1'b1;
					cow_waddr = cow_idx(p_q, new_slot);
				end
			end
			S_A_OPEN: begin
				// slot 0 reserved, slot 1 handed out
				map_we    = 1'b1;
				map_waddr = map_idx(new_idx, w_q);
				map_wdata = (w_q == '0) ? NEW_POOL_WORD0 : '0;
				cow_we    = (w_q == '0);
				cow_waddr = cow_idx(new_idx, SB'(1));
			end
			S_F_RD:  map_raddr = map_idx(p_q, slot_word);
			S_F_CHK: begin
				map_waddr = map_idx(p_q, slot_word);
				map_we    = map_rd_q[slot_q[5:0]];
				map_wdata = map_rd_q & ~(64'd1 << slot_q[5:0]);
			end
			S_C_CHK: begin
				if (cmd_q.kind == K_GET) begin
					cow_we    = 1'b1;
					cow_wdata = cow_rd_q + CNT_W'(1);
				end else if (cmd_q.kind == K_PUT) begin
					cow_we    = (cow_rd_q != '0);
					cow_wdata = cow_rd_q - CNT_W'(1);
				end
			end
			S_DONE:  rsp_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + CAB'(1);
			if (state_q == S_A_OPEN && w_q == LAST_W)
				cnt_q <= cnt_q + CB'(1);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (!qs.empty) begin
					cmd_q <= head;
					p_q   <= PB'(cnt_q - CB'(1));
					res_q <= '{
						status:     (head.kind == K_NULL) ? ST_NO_POOL : ST_DONE,
						slot_addr:  '0,
						spare_used: 1'b0,
						zeroed:     1'b0,
						ref_count:  '0
					};
				end
			end
			S_A_POOL: begin
				w_q <= '0;
				if (cnt_q != '0 && !has_room && p_q != '0)
					p_q <= p_q - PB'(1);
			end
			S_A_CHK: begin
				if (freebits != '0) begin
					used_q[p_q]     <= used_q[p_q] + USED_W'(1);
					res_q.slot_addr <= base_full + (ADDR_BITS'(new_slot) << SLOT_SHIFT);
				end else if (w_q == LAST_W) begin
					res_q.status <= ST_NO_SLOT;
				end else begin
					w_q <= w_q + WB'(1);
				end
			end
			S_A_NEW: begin
				w_q <= '0;
				if (can_open)
					base_q[new_idx] <= cmd_q.spare_pfn;
				else
					res_q.status <= ST_NO_SLOT;
			end
			S_A_OPEN: begin
				if (w_q == LAST_W) begin
					used_q[new_idx]  <= USED_W'(2);
					res_q.slot_addr  <= {base_q[new_idx], {BASE_SHIFT{1'b0}}} +
					                    (ADDR_BITS'(1) << SLOT_SHIFT);
					res_q.spare_used <= 1'b1;
				end else begin
					w_q <= w_q + WB'(1);
				end
			end
			S_SRCH: begin
				if (cnt_q == '0)
					res_q.status <= ST_NO_POOL;
				else if (hit)
					slot_q <= hit_slot;
				else if (p_q == '0)
					res_q.status <= ST_NO_POOL;
				else
					p_q <= p_q - PB'(1);
			end
			S_F_CHK: begin
				if (map_rd_q[slot_q[5:0]])
					used_q[p_q] <= used_q[p_q] - USED_W'(1);
			end
			S_C_CHK: begin
				if (cmd_q.kind == K_READ)
					res_q.ref_count <= cow_rd_q;
				if (cmd_q.kind == K_PUT && cow_rd_q == CNT_W'(1))
					res_q.zeroed <= 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we)
			map_mem[map_waddr] <= map_wdata;
		map_rd_q <= map_mem[map_raddr];
	end

	always_ff @(posedge clk) begin
		if (cow_we)
			cow_mem[cow_waddr] <= cow_wdata;
		cow_rd_q <= cow_mem[cow_raddr];
	end

	assign rsp = res_q;

	`SPA_ASSERT(a_strobe_single, clk, arst_n, rsp_valid |=> !rsp_valid)
	`SPA_ASSERT(a_pool_limit, clk, arst_n, cnt_q <= CB'(POOLS))
	`SPA_NEVER(a_pop_in_clear, clk, arst_n, ctl.pop && ctl.clearing)
	`SPA_ASSERT(a_spare_ok, clk, arst_n, (rsp_valid && rsp.spare_used) |-> (rsp.status == ST_DONE))
endmodule

// ----- hw/rtl/subpage_pool_allocator_with_cow_counts_core.sv -----
// top level of the subpage pool allocator with copy-on-write counts
// depends on spa_pkg, spa_front, spa_queue and spa_back
//
// usage: drive req and raise start; a request is taken at a clock edge with
// start high and busy low. each request gives exactly one response, shown on
// rsp for the single cycle in which rsp_valid is high; the receiver cannot
// stall, so rsp must be captured in that cycle.
// the front decodes requests into a two-entry queue; the back sequencer
// executes one request at a time and owns all state.
// each request is dequeued; then the open pools are examined, newest first;
// allocate reads bitmap words until one has a free slot, opening a new pool
// writes each of its bitmap words, free, get and put do a read-modify-write
// of the bitmap or count and read only reads its count; the response comes last.
// a null free or an unused opcode goes straight to the response.
// the back takes no new request until it has given the response to the last;
// the queue only lets the front take further requests meanwhile.
// after reset the count memory is cleared one entry a cycle, all POOLS * SLOTS
// entries (4096 at the defaults), with busy held high; no pools are open.
module subpage_pool_allocator_with_cow_counts_core #(
	parameter int POOLS = spa_pkg::POOLS_DEF,
	parameter int SLOTS = spa_pkg::SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  spa_pkg::req_t req,
	output logic          rsp_valid,
	output spa_pkg::rsp_t rsp
);
	import spa_pkg::*;

	q_stat_t   qs;
	back_ctl_t ctl;
	cmd_t      push_cmd;
	cmd_t      head;
	logic      push;

	spa_front u_front (
		.start (start),
		.busy  (busy),
		.req   (req),
		.qs    (qs),
		.ctl   (ctl),
		.push  (push),
		.cmd   (push_cmd)
	);

	spa_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (ctl.pop),
		.head     (head),
		.stat     (qs)
	);

	spa_back #(
		.POOLS (POOLS),
		.SLOTS (SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qs        (qs),
		.ctl       (ctl),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);
endmodule
